// File: rtl/riff_wave_header_parser_top_defines.svh
// Assertion macros shared by the RIFF/WAVE parser checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef RIFF_WAVE_HEADER_PARSER_TOP_DEFINES_SVH
`define RIFF_WAVE_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RWHP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwhp check failed");

// Next-cycle implication, disabled while in reset.
`define RWHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwhp check failed");

`endif

// File: rtl/rwhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; every module of the block imports this package.
package rwhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] FMT_FLOAT = 16'h0003;
    localparam logic [15:0] FMT_EXT   = 16'hFFFE;

    localparam logic [5:0] GUID_START = 6'd24;
    localparam logic [5:0] GUID_END   = 6'd40;

    localparam int DEN_W = 29;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HDR    = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NOT_WAVE  = 3'd1;
    localparam logic [2:0] ERR_FORMAT    = 3'd2;
    localparam logic [2:0] ERR_SUBTYPE   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } rwhp_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_byte;
        logic        last_sample;
        logic        format_code;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [31:0] bytes_per_second;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] frame_count;
        logic [2:0]  error_code;
    } rwhp_out_t;

    typedef enum logic [2:0] {
        OP_NONE, OP_TAG, OP_DESC, OP_TOP_SIZE, OP_SUB_SIZE, OP_FMT, OP_FACT, OP_COUNT
    } op_t;

    // Command from controller to datapath
    typedef struct packed {
        logic       take;
        op_t        op;
        logic       last;
        logic       clear;
        logic       out_load;
        logic [1:0] out_kind;
        logic [2:0] out_err;
        logic       out_last;
        logic       mul_load;
        logic       div_start;
        logic       count_load;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       out_free;
        logic       wave;
        logic       tag_riff;
        logic       tag_fmt;
        logic       tag_fact;
        logic       tag_data;
        logic       pad_zero;
        logic       riff_nz;
        logic       riff_gt4;
        logic       sub_riff_nz;
        logic       chunk_one;
        logic       count_zero;
        logic [2:0] fmt_err;
        logic       den_zero;
        logic       div_done;
    } stat_t;

    // Fixed bytes of the PCM/float subtype GUID after its first byte
    function automatic logic [7:0] guid_tail(input logic [3:0] i);
        logic [7:0] v;
        unique case (i)
            4'd6:    v = 8'h10;
            4'd8:    v = 8'h80;
            4'd11:   v = 8'hAA;
            4'd13:   v = 8'h38;
            4'd14:   v = 8'h9B;
            4'd15:   v = 8'h71;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/rwhp_stream_if.sv
// Valid/ready channel carrying one word of a packed payload type.
// Depends on nothing; the payload type comes in as a parameter.
interface rwhp_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rwhp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rwhp_pkg for the divisor width.
module rwhp_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [31:0]             dividend,
    input  logic [rwhp_pkg::DEN_W-1:0] divisor,
    output logic                    done,
    output logic [31:0]             quotient
);
    import rwhp_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]} - {1'b0, den_reg};
        if (cnt_reg != 6'd0)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= start ? 6'd32 : cnt_next;
            done_reg <= start ? 1'b0 : done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= {{(32-DEN_W){1'b0}}, divisor};
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: rtl/rwhp_dp.sv
// Datapath: tag and size assembly, fmt/fact fields, divisor and output register.
// Depends on rwhp_pkg and rwhp_div.
module rwhp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  rwhp_pkg::rwhp_in_t  in_data,
    input  rwhp_pkg::cmd_t      cmd,
    output rwhp_pkg::stat_t     stat,
    input  logic                out_ready,
    output logic                out_valid,
    output rwhp_pkg::rwhp_out_t out_data
);
    import rwhp_pkg::*;

    logic [31:0] tag_reg, chunk_reg, riff_reg, count_reg;
    logic [31:0] rate_reg, brate_reg;
    logic [15:0] ftag_reg, ch_reg, align_reg, bits_reg;
    logic        kind_reg;
    logic [1:0]  guid_reg;
    logic [5:0]  fs_reg;
    logic [DEN_W-1:0] den_reg;
    logic        out_valid_reg;
    rwhp_out_t   out_reg;
    logic [1:0]  lane_reg;

    logic [7:0]  b;
    logic [31:0] tag_shift, size_full, padded, riff_m8, sub_riff;
    logic [15:0] ftag_n, ch_n, align_n, bits_n;
    logic [31:0] rate_n, brate_n;
    logic [1:0]  guid_n;
    logic [5:0]  fs_n;
    logic [3:0]  gi;
    logic [2:0]  judge_err;
    logic        judge_kind;
    logic [31:0] product;
    logic        div_done;
    logic [31:0] quotient;
    logic        hdr;

    assign b         = in_data.stream_byte;
    assign tag_shift = {tag_reg[23:0], b};
    assign size_full = {b, chunk_reg[23:0]};
    assign padded    = size_full + {31'd0, size_full[0]};
    assign riff_m8   = (riff_reg > 32'd8) ? riff_reg - 32'd8 : 32'd0;
    assign sub_riff  = (riff_m8 > padded) ? riff_m8 - padded : 32'd0;
    assign product   = ch_reg * bits_reg;

    // Next fmt field values for the byte at offset fs_reg
    always_comb
    begin
        ftag_n  = ftag_reg;
        ch_n    = ch_reg;
        rate_n  = rate_reg;
        brate_n = brate_reg;
        align_n = align_reg;
        bits_n  = bits_reg;
        guid_n  = guid_reg;
        gi      = 4'(fs_reg - GUID_START);
        if (fs_reg < 6'd2)
            ftag_n[8*fs_reg[0] +: 8] = b;
        else if (fs_reg < 6'd4)
            ch_n[8*fs_reg[0] +: 8] = b;
        else if (fs_reg < 6'd8)
            rate_n[8*fs_reg[1:0] +: 8] = b;
        else if (fs_reg < 6'd12)
            brate_n[8*fs_reg[1:0] +: 8] = b;
        else if (fs_reg < 6'd14)
            align_n[8*fs_reg[0] +: 8] = b;
        else if (fs_reg < 6'd16)
            bits_n[8*fs_reg[0] +: 8] = b;
        else if (fs_reg >= GUID_START && fs_reg < GUID_END)
        begin
            if (gi == 4'd0)
            begin
                if (b != FMT_PCM[7:0])
                    guid_n[0] = 1'b0;
                if (b != FMT_FLOAT[7:0])
                    guid_n[1] = 1'b0;
            end
            else if (b != guid_tail(gi))
                guid_n = 2'b00;
        end
        fs_n = (fs_reg < GUID_END) ? fs_reg + 6'd1 : fs_reg;
    end

    // Format decision on the values after this byte
    always_comb
    begin
        judge_kind = 1'b0;
        judge_err  = ERR_NONE;
        if (ftag_n == FMT_PCM)
            judge_kind = 1'b0;
        else if (ftag_n == FMT_FLOAT)
            judge_kind = 1'b1;
        else if (ftag_n != FMT_EXT)
            judge_err = ERR_FORMAT;
        else if (fs_n < GUID_END)
            judge_err = ERR_SUBTYPE;
        else if (guid_n[0])
            judge_kind = 1'b0;
        else if (guid_n[1])
            judge_kind = 1'b1;
        else
            judge_err = ERR_SUBTYPE;
    end

    rwhp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (chunk_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        stat.out_free    = !out_valid_reg || out_ready;
        stat.wave        = (tag_shift == TAG_WAVE);
        stat.tag_riff    = (tag_reg == TAG_RIFF);
        stat.tag_fmt     = (tag_reg == TAG_FMT);
        stat.tag_fact    = (tag_reg == TAG_FACT);
        stat.tag_data    = (tag_reg == TAG_DATA);
        stat.pad_zero    = (padded == 32'd0);
        stat.riff_nz     = (riff_reg != 32'd0);
        stat.riff_gt4    = (riff_reg > 32'd4);
        stat.sub_riff_nz = (sub_riff != 32'd0);
        stat.chunk_one   = (chunk_reg == 32'd1);
        stat.count_zero  = (count_reg == 32'd0);
        stat.fmt_err     = judge_err;
        stat.den_zero    = (den_reg == '0);
        stat.div_done    = div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg   <= '0;
            chunk_reg <= '0;
            riff_reg  <= '0;
            count_reg <= '0;
            rate_reg  <= '0;
            brate_reg <= '0;
            ftag_reg  <= '0;
            ch_reg    <= '0;
            align_reg <= '0;
            bits_reg  <= '0;
            kind_reg  <= 1'b0;
            guid_reg  <= 2'b11;
            fs_reg    <= '0;
            den_reg   <= '0;
        end
        else if (cmd.take && cmd.clear)
        begin
            tag_reg   <= '0;
            chunk_reg <= '0;
            riff_reg  <= '0;
            count_reg <= '0;
            rate_reg  <= '0;
            brate_reg <= '0;
            ftag_reg  <= '0;
            ch_reg    <= '0;
            align_reg <= '0;
            bits_reg  <= '0;
            kind_reg  <= 1'b0;
            guid_reg  <= 2'b11;
            fs_reg    <= '0;
        end
        else
        begin
            if (cmd.mul_load)
                den_reg <= product[31:3];
            if (cmd.count_load)
                count_reg <= quotient;
            if (cmd.take)
            begin
                unique case (cmd.op)
                    OP_TAG:
                        tag_reg <= tag_shift;
                    OP_DESC:
                    begin
                        tag_reg <= tag_shift;
                        if (cmd.last && stat.wave)
                            riff_reg <= stat.riff_gt4 ? riff_reg - 32'd4 : 32'd0;
                    end
                    OP_TOP_SIZE:
                    begin
                        if (!cmd.last)
                            chunk_reg[8*lane_reg +: 8] <= b;
                        else if (stat.tag_riff)
                        begin
                            chunk_reg <= size_full;
                            riff_reg  <= size_full;
                        end
                        else
                            chunk_reg <= padded;
                    end
                    OP_SUB_SIZE:
                    begin
                        if (!cmd.last)
                            chunk_reg[8*lane_reg +: 8] <= b;
                        else
                        begin
                            chunk_reg <= padded;
                            riff_reg  <= sub_riff;
                            if (stat.tag_fmt)
                            begin
                                ftag_reg  <= '0;
                                ch_reg    <= '0;
                                rate_reg  <= '0;
                                brate_reg <= '0;
                                align_reg <= '0;
                                bits_reg  <= '0;
                                guid_reg  <= 2'b11;
                                fs_reg    <= '0;
                            end
                            else if (stat.tag_fact)
                            begin
                                count_reg <= '0;
                                fs_reg    <= '0;
                            end
                        end
                    end
                    OP_FMT:
                    begin
                        ftag_reg  <= ftag_n;
                        ch_reg    <= ch_n;
                        rate_reg  <= rate_n;
                        brate_reg <= brate_n;
                        align_reg <= align_n;
                        bits_reg  <= bits_n;
                        guid_reg  <= guid_n;
                        fs_reg    <= fs_n;
                        chunk_reg <= chunk_reg - 32'd1;
                        if (stat.chunk_one && judge_err == ERR_NONE)
                            kind_reg <= judge_kind;
                    end
                    OP_FACT:
                    begin
                        if (fs_reg < 6'd4)
                        begin
                            count_reg[8*fs_reg[1:0] +: 8] <= b;
                            fs_reg <= fs_reg + 6'd1;
                        end
                        chunk_reg <= chunk_reg - 32'd1;
                    end
                    OP_COUNT:
                        chunk_reg <= chunk_reg - 32'd1;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Size bytes arrive least significant first; advance the lane in step
    // with the controller's byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lane_reg <= '0;
        else if (cmd.take && cmd.clear)
            lane_reg <= '0;
        else if (cmd.take && (cmd.op == OP_TOP_SIZE || cmd.op == OP_SUB_SIZE))
            lane_reg <= lane_reg + 2'd1;
    end

    // Output register, freed when the word is taken
    assign hdr = (cmd.out_kind == KIND_HDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.kind             <= cmd.out_kind;
            out_reg.sample_byte      <= (cmd.out_kind == KIND_SAMPLE) ? b : 8'd0;
            out_reg.last_sample      <= cmd.out_last;
            out_reg.format_code      <= hdr ? kind_reg : 1'b0;
            out_reg.channel_count    <= hdr ? ch_reg : 16'd0;
            out_reg.rate_hz          <= hdr ? rate_reg : 32'd0;
            out_reg.bytes_per_second <= hdr ? brate_reg : 32'd0;
            out_reg.block_align      <= hdr ? align_reg : 16'd0;
            out_reg.sample_bits      <= hdr ? bits_reg : 16'd0;
            out_reg.frame_count      <= hdr ? count_reg : 32'd0;
            out_reg.error_code       <= cmd.out_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule

// File: rtl/rwhp_ctrl.sv
// Controller: chunk walk state machine, byte index and output sequencing.
// Depends on rwhp_pkg; drives the datapath through cmd_t, reads stat_t.
module rwhp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            eos,
    output logic            in_ready,
    input  rwhp_pkg::stat_t stat,
    output rwhp_pkg::cmd_t  cmd
);
    import rwhp_pkg::*;

    typedef enum logic [3:0] {
        ST_TOP_TAG, ST_TOP_SIZE, ST_TOP_SKIP, ST_DESC, ST_SUB_TAG, ST_SUB_SIZE,
        ST_FMT, ST_FACT, ST_DATA, ST_SKIP, ST_HALT, ST_MUL, ST_DEN, ST_DIV, ST_HDR
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       byte_state;
    logic       take;
    state_t     end_sub, end_sub_size;

    assign byte_state = !(state_reg == ST_MUL || state_reg == ST_DEN
                          || state_reg == ST_DIV || state_reg == ST_HDR);
    assign in_ready   = byte_state && stat.out_free;
    assign take       = in_valid && in_ready;
    assign end_sub      = stat.riff_nz ? ST_SUB_TAG : ST_TOP_TAG;
    assign end_sub_size = stat.sub_riff_nz ? ST_SUB_TAG : ST_TOP_TAG;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        cmd.take   = take;
        cmd.last   = (idx_reg == 2'd3);
        unique case (state_reg)
            ST_TOP_TAG, ST_SUB_TAG:
            begin
                cmd.op = OP_TAG;
                if (take)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (cmd.last)
                        state_next = (state_reg == ST_TOP_TAG) ? ST_TOP_SIZE : ST_SUB_SIZE;
                end
            end
            ST_DESC:
            begin
                cmd.op = OP_DESC;
                if (take)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (cmd.last)
                    begin
                        if (!stat.wave)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_ERR;
                            cmd.out_err  = ERR_NOT_WAVE;
                            state_next   = ST_HALT;
                        end
                        else
                            state_next = stat.riff_gt4 ? ST_SUB_TAG : ST_TOP_TAG;
                    end
                end
            end
            ST_TOP_SIZE:
            begin
                cmd.op = OP_TOP_SIZE;
                if (take)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (cmd.last)
                    begin
                        if (stat.tag_riff)
                            state_next = ST_DESC;
                        else
                            state_next = stat.pad_zero ? ST_TOP_TAG : ST_TOP_SKIP;
                    end
                end
            end
            ST_SUB_SIZE:
            begin
                cmd.op = OP_SUB_SIZE;
                if (take)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (cmd.last)
                    begin
                        priority if (stat.tag_fmt)
                        begin
                            if (stat.pad_zero)
                            begin
                                // empty fmt chunk leaves a zero format tag
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_ERR;
                                cmd.out_err  = ERR_FORMAT;
                                state_next   = ST_HALT;
                            end
                            else
                                state_next = ST_FMT;
                        end
                        else if (stat.tag_fact)
                            state_next = stat.pad_zero ? end_sub_size : ST_FACT;
                        else if (stat.tag_data)
                        begin
                            if (eos && !stat.pad_zero)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_ERR;
                                cmd.out_err  = ERR_TRUNCATED;
                                state_next   = ST_HALT;
                            end
                            else if (stat.count_zero && !stat.pad_zero)
                                state_next = ST_MUL;
                            else
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_HDR;
                                state_next   = stat.pad_zero ? end_sub_size : ST_DATA;
                            end
                        end
                        else
                            state_next = stat.pad_zero ? end_sub_size : ST_SKIP;
                    end
                end
            end
            ST_FMT:
            begin
                cmd.op = OP_FMT;
                if (take && stat.chunk_one)
                begin
                    if (stat.fmt_err != ERR_NONE)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_ERR;
                        cmd.out_err  = stat.fmt_err;
                        state_next   = ST_HALT;
                    end
                    else
                        state_next = end_sub;
                end
            end
            ST_FACT:
            begin
                cmd.op = OP_FACT;
                if (take && stat.chunk_one)
                    state_next = end_sub;
            end
            ST_DATA:
            begin
                cmd.op = OP_COUNT;
                if (take)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.chunk_one)
                    begin
                        cmd.out_kind = KIND_SAMPLE;
                        cmd.out_last = 1'b1;
                        state_next   = end_sub;
                    end
                    else if (eos)
                    begin
                        cmd.out_kind = KIND_ERR;
                        cmd.out_err  = ERR_TRUNCATED;
                        state_next   = ST_HALT;
                    end
                    else
                        cmd.out_kind = KIND_SAMPLE;
                end
            end
            ST_TOP_SKIP:
            begin
                cmd.op = OP_COUNT;
                if (take && stat.chunk_one)
                    state_next = ST_TOP_TAG;
            end
            ST_SKIP:
            begin
                cmd.op = OP_COUNT;
                if (take && stat.chunk_one)
                    state_next = end_sub;
            end
            ST_HALT:
            begin
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_DEN;
            end
            ST_DEN:
            begin
                // zero divisor leaves the count at zero
                if (stat.den_zero)
                    state_next = ST_HDR;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.count_load = 1'b1;
                    state_next     = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_HDR;
                    state_next   = ST_DATA;
                end
            end
            default:
                state_next = ST_TOP_TAG;
        endcase
        if (take && eos)
        begin
            cmd.clear  = 1'b1;
            state_next = ST_TOP_TAG;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TOP_TAG;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

// File: rtl/riff_wave_header_parser_top.sv
// Top level of the RIFF/WAVE header parser: controller plus datapath.
// Depends on rwhp_pkg, rwhp_stream_if, rwhp_ctrl, rwhp_dp and rwhp_div.
//
// Feed the file one byte per word on in_stream, end_of_stream set on its
// final byte. The parser walks the RIFF chunks, skips what it does not know,
// decodes fmt and fact, sends one header word at the data chunk and then
// every padded payload byte, the last one flagged; errors go out as an error
// word, after which bytes are dropped until end_of_stream, which returns the
// parser to its reset state. Throughput is one byte per cycle as long as
// out_stream takes each word; the output register holds one word so a byte
// can be accepted in the same cycle the previous result leaves. When a data
// chunk arrives with no fact count, the frame count is the padded data size
// over (channels * bits) / 8: input stalls through the multiply, the divisor
// check, the one-bit-per-cycle divider and the header load, in that order,
// with the divider skipped when the divisor is zero; a stalled out_stream
// lengthens the header load.
module riff_wave_header_parser_top (
    input  logic           clk,
    input  logic           rst_n,
    rwhp_stream_if.sink    in_stream,
    rwhp_stream_if.source  out_stream
);
    import rwhp_pkg::*;

    cmd_t      cmd;
    stat_t     stat;
    rwhp_in_t  in_word;
    rwhp_out_t out_word;

    assign in_word = in_stream.data;

    // Sequence the chunk walk and the header divide
    rwhp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_stream.valid),
        .eos      (in_word.end_of_stream),
        .in_ready (in_stream.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold fields, sizes and the output word
    rwhp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_stream.ready),
        .out_valid (out_stream.valid),
        .out_data  (out_word)
    );

    assign out_stream.data = out_word;
endmodule

// File: rtl/rwhp_checker.sv
// Port-level checks for the RIFF/WAVE header parser, bound to the top level.
// Depends on rwhp_pkg and riff_wave_header_parser_top_defines.svh.
`include "riff_wave_header_parser_top_defines.svh"

module rwhp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input rwhp_pkg::rwhp_out_t out_data
);
    import rwhp_pkg::*;

    `RWHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `RWHP_ASSERT_NOW(a_last_is_sample, out_valid && out_data.last_sample, out_data.kind == KIND_SAMPLE)
    `RWHP_ASSERT_NOW(a_err_code, out_valid, (out_data.kind == KIND_ERR) == (out_data.error_code != ERR_NONE))
    `RWHP_ASSERT_NOW(a_hdr_only_fields, out_valid && out_data.kind != KIND_HDR, out_data.channel_count == 16'd0 && out_data.frame_count == 32'd0)
endmodule

bind riff_wave_header_parser_top rwhp_checker u_rwhp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_data  (out_stream.data)
);
